/* hdl/igfr_pkg.sv */
// Shared types and constants of the idle-gap frame receiver.
// No dependencies; used by igfr_drain and idle_gap_frame_receiver_top.
package igfr_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int CNT_W        = $clog2(BUFFER_DEPTH);
  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 6;
  localparam int GAP_W        = 10;
  localparam int OUT_TDATA_W  = ((BYTE_W + LEN_W + 7) / 8) * 8;

  localparam logic [GAP_W-1:0] GAP_CEILING = GAP_W'(1000);
  localparam logic [GAP_W-1:0] GAP_RESET   = GAP_W'(5);

  // item kinds carried in in_tuser
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [LEN_W-1:0]       len_t;
  typedef logic [GAP_W-1:0]       gap_t;
  typedef logic [BYTE_W-1:0]      byte_t;
  typedef logic [OUT_TDATA_W-1:0] out_tdata_t;

  // request from intake to the drain sequencer
  typedef struct packed {
    logic start;
    cnt_t n;
  } drain_req_t;

  // drain sequencer states
  typedef enum logic [1:0] {
    DR_IDLE = 2'b01,
    DR_LOAD = 2'b10
  } drain_state_t;

endpackage

/* hdl/igfr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module igfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/igfr_drain.sv */
// Drain sequencer: reads a closed frame out of the frame store and drives
// the result channel through an output register. Depends on igfr_pkg.
module igfr_drain (
  input  logic                     clk,
  input  logic                     rst_n,
  input  igfr_pkg::drain_req_t     req,
  output logic                     busy,
  output logic                     rd_en,
  output igfr_pkg::cnt_t           rd_addr,
  input  igfr_pkg::byte_t          rd_data,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output igfr_pkg::out_tdata_t     out_tdata,   // [7:0] frame_byte, [13:8] frame_length
  output logic                     out_tlast    // last_byte
);

  igfr_pkg::drain_state_t state_r, state_nxt;
  igfr_pkg::cnt_t         k_r, k_nxt;
  igfr_pkg::cnt_t         n_r, n_nxt;
  logic                   out_valid_r, out_valid_nxt;
  igfr_pkg::out_tdata_t   out_data_r, out_data_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   room;
  logic                   at_last;

  assign room    = !out_valid_r || out_tready;
  assign at_last = (k_r == n_r - 1'b1);

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    rd_addr       = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      igfr_pkg::DR_IDLE: begin
        if (req.start) begin
          rd_en     = 1'b1;
          rd_addr   = '0;
          k_nxt     = '0;
          n_nxt     = req.n;
          state_nxt = igfr_pkg::DR_LOAD;
        end
      end
      igfr_pkg::DR_LOAD: begin
        // read data for entry k sits in the ram output register
        if (room) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = igfr_pkg::out_tdata_t'({igfr_pkg::len_t'(n_r), rd_data});
          out_last_nxt  = at_last;
          if (at_last) begin
            state_nxt = igfr_pkg::DR_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = k_r + 1'b1;
            k_nxt   = k_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = igfr_pkg::DR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= igfr_pkg::DR_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    n_r        <= n_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy       = (state_r == igfr_pkg::DR_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == igfr_pkg::DR_IDLE)
    else $error("drain started while busy");

  a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> req.n != '0)
    else $error("drain started on an empty frame");

  a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == igfr_pkg::DR_LOAD |-> k_r < n_r)
    else $error("drain index beyond frame length");

endmodule

/* hdl/idle_gap_frame_receiver_top.sv */
// Top level of the idle-gap frame receiver: intake counters, gap register
// and frame store. Depends on igfr_pkg, igfr_ram and igfr_drain.

// Every input beat, received byte or timer tick, is accepted while no drain is
// running. A tick that closes a nonempty frame starts a drain that reads the
// frame store one entry at a time through its registered read port; a result
// beat is produced every cycle after the first while the result side keeps up,
// and intake is held off for the whole drain, which stretches if the result
// side stalls. Intake resumes as soon as the last byte sits in the output
// register. A byte that fills the buffer drops the partial frame. gap_ticks
// may be written only while the block is idle; the store needs no clearing
// after reset.
module idle_gap_frame_receiver_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [igfr_pkg::BYTE_W-1:0] in_tdata,   // [7:0] rx_byte
  input  logic                        in_tuser,   // func
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output igfr_pkg::out_tdata_t        out_tdata,  // [7:0] frame_byte, [13:8] frame_length
  output logic                        out_tlast,  // last_byte
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [igfr_pkg::GAP_W-1:0]  cfg_data    // gap_ticks
);

  igfr_pkg::cnt_t       count_r, count_nxt;
  igfr_pkg::gap_t       gap_r, gap_nxt;
  igfr_pkg::gap_t       gap_ticks_r;
  igfr_pkg::gap_t       gap_inc;
  logic [igfr_pkg::CNT_W:0] count_sum;
  logic                 in_accept;
  logic                 wr_en;
  logic                 busy;
  logic                 rd_en;
  igfr_pkg::cnt_t       rd_addr;
  igfr_pkg::byte_t      rd_data;
  igfr_pkg::drain_req_t req;

  assign in_tready = !busy;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign count_sum = {1'b0, count_r} + 1'b1;
  assign gap_inc   = (gap_r != '0 && gap_r < igfr_pkg::GAP_CEILING) ? gap_r + 1'b1 : gap_r;

  always_comb begin
    count_nxt = count_r;
    gap_nxt   = gap_r;
    wr_en     = 1'b0;
    req.start = 1'b0;
    req.n     = count_r;
    if (in_accept) begin
      if (in_tuser == igfr_pkg::FUNC_BYTE) begin
        wr_en = 1'b1;
        if (count_sum >= (igfr_pkg::CNT_W + 1)'(igfr_pkg::BUFFER_DEPTH)) begin
          // buffer full, drop the partial frame
          count_nxt = '0;
          gap_nxt   = '0;
        end else begin
          count_nxt = count_sum[igfr_pkg::CNT_W-1:0];
          gap_nxt   = igfr_pkg::gap_t'(1);
        end
      end else if (gap_inc >= gap_ticks_r) begin
        count_nxt = '0;
        gap_nxt   = '0;
        req.start = (count_r != '0);
      end else begin
        gap_nxt = gap_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      gap_r       <= '0;
      gap_ticks_r <= igfr_pkg::GAP_RESET;
    end else begin
      count_r <= count_nxt;
      gap_r   <= gap_nxt;
      if (cfg_valid && cfg_ready) begin
        gap_ticks_r <= cfg_data;
      end
    end
  end

  igfr_ram #(
    .WIDTH (igfr_pkg::BYTE_W),
    .DEPTH (igfr_pkg::BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r),
    .wdata (in_tdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  igfr_drain u_drain (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .busy       (busy),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_gap_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
    gap_r <= igfr_pkg::GAP_CEILING)
    else $error("gap counter above ceiling");

  a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !wr_en)
    else $error("frame store written during drain");

  a_count_cleared_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> count_r == '0 && gap_r == '0)
    else $error("counters not cleared when frame closed");

endmodule
